// File: rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;

    localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN   = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
    localparam logic [CHAR_W-1:0] RESET_COLOR = 8'd7;

    typedef enum logic [2:0] {
        OP_PRINT  = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_SETCUR = 3'd2,
        OP_WRITE  = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_DRAIN,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [CHAR_W-1:0] char_code;
        logic [CHAR_W-1:0] color;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_item;

    typedef struct packed {
        logic              valid;
        logic [ROW_W-1:0]  pos_row;
        logic [COL_W-1:0]  pos_col;
        logic [CHAR_W-1:0] read_char;
    } t_result;

endpackage

// File: rtl/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tcw_addr.sv
// Shared cell address unit: row * columns + column.
module tcw_addr #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic [tcw_pkg::ROW_W-1:0]                 i_row,
    input  logic [tcw_pkg::COL_W-1:0]                 i_col,
    output logic [$clog2(SCREEN_ROWS*SCREEN_COLS)-1:0] o_addr,
    output logic                                      o_in_range
);
    import tcw_pkg::*;

    localparam int AW = $clog2(SCREEN_ROWS * SCREEN_COLS);

    assign o_addr     = AW'(AW'(i_row) * AW'(SCREEN_COLS) + AW'(i_col));
    assign o_in_range = (i_row < ROW_W'(SCREEN_ROWS)) && (i_col < COL_W'(SCREEN_COLS));

endmodule

// File: rtl/tcw_seq.sv
// Operation sequencer: cursor, cell store, scroll, clear and init sweeps.
module tcw_seq #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  tcw_pkg::t_item              i_item,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_blank_color,
    output logic                        o_idle,
    output tcw_pkg::t_result            o_res
);
    import tcw_pkg::*;

    localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(SCREEN_COLS);
    localparam logic [AW-1:0] BOTTOM_A  = AW'(CELLS - SCREEN_COLS);

    t_state r_state, n_state;
    logic [AW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]    r_waddr, n_waddr;
    logic             r_pend, n_pend;
    logic             r_rd_oor, n_rd_oor;
    logic [ROW_W-1:0] r_cur_row, n_cur_row;
    logic [COL_W-1:0] r_cur_col, n_cur_col;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata, mem_rdata;

    logic [ROW_W-1:0] a_row;
    logic [COL_W-1:0] a_col;
    logic [AW-1:0]    addr;
    logic             tgt_ok;

    logic [ROW_W-1:0] p_row;
    logic [7:0]       p_col;
    logic             p_store;
    logic             p_scroll;

    // print uses the cursor, all other operations the target
    assign a_row = (i_item.opcode == OP_PRINT) ? r_cur_row : i_item.row;
    assign a_col = (i_item.opcode == OP_PRINT) ? r_cur_col : i_item.col;

    tcw_addr #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) u_addr (
        .i_row     (a_row),
        .i_col     (a_col),
        .o_addr    (addr),
        .o_in_range(tgt_ok)
    );

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // cursor motion for a printed character
    always_comb begin
        p_row   = r_cur_row;
        p_col   = {1'b0, r_cur_col};
        p_store = 1'b0;
        case (i_item.char_code)
            CH_NEWLINE: begin
                p_row = r_cur_row + 1'b1;
                p_col = '0;
            end
            CH_RETURN: begin
                p_col = '0;
            end
            CH_TAB: begin
                p_col = ({1'b0, r_cur_col} + 8'd4) & 8'hFC;
            end
            default: begin
                p_store = 1'b1;
                p_col   = {1'b0, r_cur_col} + 8'd1;
            end
        endcase
        if (p_col >= 8'(SCREEN_COLS)) begin
            p_col = '0;
            p_row = p_row + 1'b1;
        end
        p_scroll = (p_row >= ROW_W'(SCREEN_ROWS));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_cnt == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_item_valid) begin
                    case (i_item.opcode)
                        OP_PRINT: n_state = p_scroll ? ST_COPY : ST_IDLE;
                        OP_CLEAR: n_state = ST_FILL;
                        OP_READ:  n_state = ST_READ;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:  n_state = ST_IDLE;
            ST_COPY: begin
                if (r_cnt == LAST_ADDR) n_state = ST_DRAIN;
            end
            ST_DRAIN: n_state = ST_FILL;
            ST_FILL: begin
                if (r_cnt == LAST_ADDR) n_state = ST_IDLE;
            end
            default:  n_state = ST_INIT;
        endcase
    end

    always_comb begin
        mem_we          = 1'b0;
        mem_waddr       = addr;
        mem_wdata       = {i_item.color, i_item.char_code};
        mem_re          = 1'b0;
        mem_raddr       = addr;
        n_cnt           = r_cnt;
        n_waddr         = r_waddr;
        n_pend          = 1'b0;
        n_rd_oor        = r_rd_oor;
        n_cur_row       = r_cur_row;
        n_cur_col       = r_cur_col;
        o_res.valid     = 1'b0;
        o_res.read_char = '0;
        case (r_state)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = {RESET_COLOR, CH_SPACE};
                n_cnt     = r_cnt + 1'b1;
            end
            ST_IDLE: begin
                if (i_item_valid) begin
                    case (i_item.opcode)
                        OP_PRINT: begin
                            mem_we = p_store;
                            if (p_scroll) begin
                                n_cur_row = ROW_W'(SCREEN_ROWS - 1);
                                n_cur_col = '0;
                                n_cnt     = COLS_A;
                            end else begin
                                n_cur_row   = p_row;
                                n_cur_col   = p_col[COL_W-1:0];
                                o_res.valid = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_cur_row = '0;
                            n_cur_col = '0;
                            n_cnt     = '0;
                        end
                        OP_SETCUR: begin
                            if (tgt_ok) begin
                                n_cur_row = i_item.row;
                                n_cur_col = i_item.col;
                            end
                            o_res.valid = 1'b1;
                        end
                        OP_WRITE: begin
                            mem_we      = tgt_ok;
                            o_res.valid = 1'b1;
                        end
                        OP_READ: begin
                            mem_re   = tgt_ok;
                            n_rd_oor = !tgt_ok;
                        end
                        default: begin
                            o_res.valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                o_res.valid     = 1'b1;
                o_res.read_char = r_rd_oor ? CH_SPACE : mem_rdata[CHAR_W-1:0];
            end
            ST_COPY: begin
                // read one line below, write the previous read one line up
                mem_re    = 1'b1;
                mem_raddr = r_cnt;
                mem_we    = r_pend;
                mem_waddr = r_waddr;
                mem_wdata = mem_rdata;
                n_pend    = 1'b1;
                n_waddr   = r_cnt - COLS_A;
                n_cnt     = (r_cnt == LAST_ADDR) ? BOTTOM_A : r_cnt + 1'b1;
            end
            ST_DRAIN: begin
                mem_we    = 1'b1;
                mem_waddr = r_waddr;
                mem_wdata = mem_rdata;
            end
            ST_FILL: begin
                mem_we      = 1'b1;
                mem_waddr   = r_cnt;
                mem_wdata   = {i_blank_color, CH_SPACE};
                n_cnt       = r_cnt + 1'b1;
                o_res.valid = (r_cnt == LAST_ADDR);
            end
            default: begin
                n_cnt = '0;
            end
        endcase
        o_res.pos_row = n_cur_row;
        o_res.pos_col = n_cur_col;
    end

    assign o_idle = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_cur_row <= '0;
            r_cur_col <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_pend    <= n_pend;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr  <= n_waddr;
        r_rd_oor <= n_rd_oor;
    end

endmodule

// File: rtl/text_console_writer.sv
// Top level of the text console writer: stream ports, APB register, result register.
//
// Text console with a SCREEN_ROWS x SCREEN_COLS store of 16-bit cells in one
// dual-port RAM (one write and one registered read per cycle) and a cursor.
// One command beat yields one result beat. Print without a scroll, set cursor,
// write at and unused opcodes finish in the cycle the beat is taken; read at
// finishes in ST_READ, after the registered RAM read. A new beat is taken only
// once the result of the last one has been taken. A print that runs past the
// last row scrolls: the RAM port moves one cell a cycle. Clear sweeps the whole
// store. After reset the store is swept to spaces in color 7, with s_tready low;
// blank_color writes are taken throughout.
module text_console_writer #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // opcode[2:0] char_code[10:3] color[18:11] row[23:19] col[30:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pos_row_out[4:0] pos_col_out[11:5] read_char[19:12]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcw_pkg::*;

    logic [CHAR_W-1:0] r_blank_color;
    logic              r_out_valid, n_out_valid;
    logic [19:0]       r_out_data;
    logic              seq_idle;
    logic              accept;
    t_item             item;
    t_result           res;

    assign item.opcode    = s_tdata[2:0];
    assign item.char_code = s_tdata[10:3];
    assign item.color     = s_tdata[18:11];
    assign item.row       = s_tdata[23:19];
    assign item.col       = s_tdata[30:24];

    assign s_tready = seq_idle && !r_out_valid;
    assign accept   = s_tvalid && s_tready;

    tcw_seq #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (accept),
        .i_item       (item),
        .i_blank_color(r_blank_color),
        .o_idle       (seq_idle),
        .o_res        (res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (res.valid) begin
            n_out_valid = 1'b1;
        end else if (m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_blank_color <= RESET_COLOR;
        end else begin
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && pready && !paddr[2]) begin
                r_blank_color <= pwdata[CHAR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_data <= {res.read_char, res.pos_col, res.pos_row};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'd0, r_out_data};
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {24'd0, r_blank_color};

endmodule

// File: rtl/tcw_checker.sv
// Port-level checks of the text console writer and their bind.
module tcw_checker #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[4:0] < 5'(SCREEN_ROWS)) && (m_tdata[11:5] < 7'(SCREEN_COLS)))
        else $error("cursor out of screen");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while previous one in flight");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !s_tready)
        else $error("command taken with a result pending");

endmodule

bind text_console_writer tcw_checker #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
) u_tcw_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// File: dv/text_console_writer_tb.sv
// Self-checking testbench of the text console writer: directed and random commands, scoreboard.
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_TAIL = 2100;
    localparam int ITEMS_PER_PHASE = 150;
    localparam logic [2:0] ADDR_BLANK_COLOR = 3'd0;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] rd;
    } t_status;

    class console_scoreboard;
        logic [CELL_W-1:0] cells [ROWS*COLS];
        int cur_row;
        int cur_col;
        logic [CHAR_W-1:0] blank;
        t_status status_due [$];
        int fails;

        function new();
            foreach (cells[i]) cells[i] = {RESET_COLOR, CH_SPACE};
            cur_row = 0;
            cur_col = 0;
            blank = RESET_COLOR;
            fails = 0;
        endfunction

        function void set_blank(logic [CHAR_W-1:0] c);
            blank = c;
        endfunction

        function int pending();
            return status_due.size();
        endfunction

        function bit on_screen(int r, int c);
            return r < ROWS && c < COLS;
        endfunction

        function void scroll_up();
            for (int i = COLS; i < ROWS*COLS; i++) cells[i-COLS] = cells[i];
            for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++) cells[i] = {blank, CH_SPACE};
            cur_row = ROWS - 1;
            cur_col = 0;
        endfunction

        function void put_glyph(logic [CHAR_W-1:0] ch, logic [CHAR_W-1:0] attr);
            if (ch == CH_NEWLINE) begin
                cur_row++;
                cur_col = 0;
            end else if (ch == CH_RETURN) begin
                cur_col = 0;
            end else if (ch == CH_TAB) begin
                cur_col = (cur_col + 4) & ~3;
            end else begin
                if (on_screen(cur_row, cur_col)) cells[cur_row*COLS + cur_col] = {attr, ch};
                cur_col++;
            end
            if (cur_col >= COLS) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= ROWS) scroll_up();
        endfunction

        function void take_command(logic [31:0] beat);
            logic [2:0]        op;
            logic [CHAR_W-1:0] ch;
            logic [CHAR_W-1:0] attr;
            int                r;
            int                c;
            t_status           st;
            op   = beat[2:0];
            ch   = beat[10:3];
            attr = beat[18:11];
            r    = int'(beat[23:19]);
            c    = int'(beat[30:24]);
            st.rd = '0;
            case (op)
                OP_PRINT: put_glyph(ch, attr);
                OP_CLEAR: begin
                    foreach (cells[i]) cells[i] = {blank, CH_SPACE};
                    cur_row = 0;
                    cur_col = 0;
                end
                OP_SETCUR: begin
                    if (on_screen(r, c)) begin
                        cur_row = r;
                        cur_col = c;
                    end
                end
                OP_WRITE: if (on_screen(r, c)) cells[r*COLS + c] = {attr, ch};
                OP_READ:  st.rd = on_screen(r, c) ? cells[r*COLS + c][CHAR_W-1:0] : CH_SPACE;
                default: ;
            endcase
            st.row = cur_row[ROW_W-1:0];
            st.col = cur_col[COL_W-1:0];
            status_due.push_back(st);
        endfunction

        function void flag(string what, logic [CHAR_W-1:0] want, logic [CHAR_W-1:0] got);
            fails++;
            if (fails <= 200)
                $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        endfunction

        function void check_status(logic [23:0] beat);
            t_status got;
            t_status want;
            got.row = beat[4:0];
            got.col = beat[11:5];
            got.rd  = beat[19:12];
            if (status_due.size() == 0) begin
                fails++;
                if (fails <= 200)
                    $display("%0t: unexpected beat, actual row %0h col %0h char %0h",
                             $time, got.row, got.col, got.rd);
                return;
            end
            want = status_due.pop_front();
            if (got.row !== want.row) flag("pos_row", 8'(want.row), 8'(got.row));
            if (got.col !== want.col) flag("pos_col", 8'(want.col), 8'(got.col));
            if (got.rd !== want.rd) flag("read_char", want.rd, got.rd);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // opcode[2:0] char_code[10:3] color[18:11] row[23:19] col[30:24]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // pos_row_out[4:0] pos_col_out[11:5] read_char[19:12]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    console_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    text_console_writer #(
        .SCREEN_COLS(COLS),
        .SCREEN_ROWS(ROWS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) sb.check_status(m_tdata);
            if (s_tvalid && s_tready) sb.take_command(s_tdata);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_item cmd(logic [2:0] op, logic [CHAR_W-1:0] ch, logic [CHAR_W-1:0] attr,
                                  int r, int c);
        t_item it;
        it.opcode    = op;
        it.char_code = ch;
        it.color     = attr;
        it.row       = r[ROW_W-1:0];
        it.col       = c[COL_W-1:0];
        return it;
    endfunction

    function automatic t_item random_cmd();
        t_item       it;
        int unsigned pick;
        it.char_code = 8'($urandom_range(255));
        it.color     = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 10) begin
            it.row = 5'($urandom_range(31));
            it.col = 7'($urandom_range(127));
        end else if (pick < 60) begin
            it.row = 5'($urandom_range(ROWS-1, ROWS-3));
            it.col = 7'($urandom_range(1) ? $urandom_range(7) : $urandom_range(COLS-1, COLS-8));
        end else begin
            it.row = 5'($urandom_range(ROWS-1));
            it.col = 7'($urandom_range(COLS-1));
        end
        pick = $urandom_range(99);
        if (pick < 48) begin
            it.opcode = OP_PRINT;
            pick = $urandom_range(99);
            if (pick < 8) it.char_code = CH_NEWLINE;
            else if (pick < 13) it.char_code = CH_RETURN;
            else if (pick < 23) it.char_code = CH_TAB;
        end else if (pick < 63) begin
            it.opcode = OP_SETCUR;
        end else if (pick < 77) begin
            it.opcode = OP_WRITE;
        end else if (pick < 95) begin
            it.opcode = OP_READ;
        end else if (pick < 97) begin
            it.opcode = OP_CLEAR;
        end else begin
            it.opcode = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end
        return it;
    endfunction

    task automatic send_cmd(input t_item it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, it.col, it.row, it.color, it.char_code, it.opcode};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_blank_color(input logic [CHAR_W-1:0] c);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BLANK_COLOR;
        pwdata  <= {24'd0, c};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_blank(c);
    endtask

    initial begin
        t_item       directed [$];
        logic [7:0]  phase_color [4];
        int          phase_send [4];
        int          phase_stall [4];
        sb = new();
        phase_color = '{8'h00, 8'hFF, 8'h00, 8'h00};
        phase_color[2] = 8'($urandom_range(255));
        phase_color[3] = 8'($urandom_range(255));
        phase_send  = '{0, 60, 0, 21};
        phase_stall = '{0, 0, 60, 21};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_blank_color(8'hFF);

        directed.push_back(cmd(OP_READ, 8'h00, 8'h00, 0, 0));
        directed.push_back(cmd(OP_PRINT, 8'h00, 8'h00, 0, 0));
        directed.push_back(cmd(OP_PRINT, 8'hFF, 8'hFF, 31, 127));
        directed.push_back(cmd(OP_READ, 8'h00, 8'h00, 0, 1));
        directed.push_back(cmd(OP_PRINT, CH_TAB, 8'h00, 0, 0));
        directed.push_back(cmd(OP_PRINT, CH_RETURN, 8'h00, 0, 0));
        directed.push_back(cmd(OP_PRINT, CH_NEWLINE, 8'h00, 0, 0));
        // tab close to the line end wraps onto the next row, here past the last one
        directed.push_back(cmd(OP_SETCUR, 8'h00, 8'h00, ROWS-1, COLS-2));
        directed.push_back(cmd(OP_PRINT, CH_TAB, 8'h00, 0, 0));
        directed.push_back(cmd(OP_SETCUR, 8'h00, 8'h00, ROWS, COLS));
        directed.push_back(cmd(OP_SETCUR, 8'h00, 8'h00, 31, 127));
        directed.push_back(cmd(OP_SETCUR, 8'h00, 8'h00, 0, COLS-1));
        directed.push_back(cmd(OP_PRINT, 8'h41, 8'h1E, 0, 0));
        directed.push_back(cmd(OP_WRITE, 8'h7E, 8'h00, ROWS-1, COLS-1));
        directed.push_back(cmd(OP_WRITE, 8'h55, 8'hAA, ROWS, 0));
        directed.push_back(cmd(OP_READ, 8'h00, 8'h00, ROWS-1, COLS-1));
        directed.push_back(cmd(OP_READ, 8'h00, 8'h00, 0, COLS));
        directed.push_back(cmd(OP_SETCUR, 8'h00, 8'h00, ROWS-1, COLS-1));
        directed.push_back(cmd(OP_PRINT, 8'h80, 8'h5A, 0, 0));
        directed.push_back(cmd(OP_READ, 8'h00, 8'h00, ROWS-2, COLS-1));
        directed.push_back(cmd(OP_READ, 8'h00, 8'h00, ROWS-1, 5));
        directed.push_back(cmd(OP_PRINT, CH_NEWLINE, 8'h00, 0, 0));
        directed.push_back(cmd(OP_SPARE_LO, 8'hFF, 8'hFF, 31, 127));
        directed.push_back(cmd(OP_SPARE_HI, 8'h00, 8'h00, 0, 0));
        directed.push_back(cmd(OP_CLEAR, 8'h00, 8'h00, 0, 0));
        directed.push_back(cmd(OP_READ, 8'h00, 8'h00, ROWS-3, COLS-1));
        foreach (directed[i]) send_cmd(directed[i]);

        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            write_blank_color(phase_color[ph]);
            send_idle_pct = phase_send[ph];
            stall_pct     = phase_stall[ph];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(49) == 0) wait_drained();
                send_cmd(random_cmd());
            end
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
